@@ hw/rtl/decu_pkg.sv @@
// ----------------------------------------------------------------------------
// decu_pkg
// Shared types and constants of the disc elastic collision update block.
// ----------------------------------------------------------------------------
package decu_pkg;

  localparam int unsigned DivNumW  = 58;  // dividend width
  localparam int unsigned DivDenW  = 32;  // divisor width
  localparam int unsigned DivQuoW  = 27;  // quotient width, one bit per step
  localparam int unsigned DivCntW  = 5;

  typedef enum logic [1:0] {
    CMD_BORDER = 2'd0,
    CMD_BALL   = 2'd1,
    CMD_MOVE   = 2'd2,
    CMD_SET    = 2'd3
  } cmd_e;

  typedef struct packed {
    logic               start;
    logic [DivNumW-1:0] num;
    logic [DivDenW-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [DivQuoW-1:0] quo;
  } div_rsp_t;

endpackage

@@ hw/rtl/disc_elastic_collision_update_top.sv @@
// ----------------------------------------------------------------------------
// disc_elastic_collision_update_top
// Velocity, position and hit counters of one disc under elastic collisions.
// ----------------------------------------------------------------------------
// The block holds one transaction at a time: in_stall_o is high from accept
// until the result transaction leaves. out_valid_o rises in the cycle after
// accept for a border hit or set velocity; a move tick first passes through
// S_MV_Y and S_MV_F, and a ball hit through the norm, dot product, multiply
// and divide steps (the mass-ratio divide is skipped when both masses are
// zero). The block returns to idle in the cycle after the result is taken.
// The ball hit time is set by the shared 27-step bit-serial divider, which
// runs four times (projection and mass ratio, for x and for y; two when both
// masses are zero), and by the single shared multiplier that forms every
// product in turn. A zero-length axis sends a ball hit from S_CHK straight
// to the result, with degenerate set. own_mass is written through the config
// channel, which is always ready; write it only while the block is idle.
module disc_elastic_collision_update_top
  import decu_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic        [15:0] cfg_own_mass_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic        [1:0]  command_i,
  input  logic signed [15:0] axis_x_i,
  input  logic signed [15:0] axis_y_i,
  input  logic signed [23:0] other_vel_x_i,
  input  logic signed [23:0] other_vel_y_i,
  input  logic        [15:0] other_mass_i,
  input  logic        [15:0] delta_time_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [23:0] vel_x_o,
  output logic signed [23:0] vel_y_o,
  output logic signed [31:0] pos_x_o,
  output logic signed [31:0] pos_y_o,
  output logic        [15:0] ball_hits_o,
  output logic        [15:0] border_hits_o,
  output logic               degenerate_o
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_NRM_X = 4'd1;
  localparam logic [3:0] S_NRM_Y = 4'd2;
  localparam logic [3:0] S_DOT_X = 4'd3;
  localparam logic [3:0] S_DOT_Y = 4'd4;
  localparam logic [3:0] S_CHK   = 4'd5;
  localparam logic [3:0] S_TMUL  = 4'd6;
  localparam logic [3:0] S_TDIV  = 4'd7;
  localparam logic [3:0] S_TWAIT = 4'd8;
  localparam logic [3:0] S_LMUL  = 4'd9;
  localparam logic [3:0] S_LDIV  = 4'd10;
  localparam logic [3:0] S_LWAIT = 4'd11;
  localparam logic [3:0] S_APPLY = 4'd12;
  localparam logic [3:0] S_MV_Y  = 4'd13;
  localparam logic [3:0] S_MV_F  = 4'd14;
  localparam logic [3:0] S_OUT   = 4'd15;

  localparam logic signed [23:0] VelMax = 24'sh7FFFFF;
  localparam logic signed [23:0] VelMin = -24'sh800000;
  localparam logic signed [31:0] PosMax = 32'sh7FFFFFFF;
  localparam logic signed [31:0] PosMin = -32'sh80000000;

  logic [3:0] state_q, state_d;

  // Item fields, held for the whole transaction.
  logic [1:0]         cmd_q;
  logic signed [15:0] ax_q, ay_q;
  logic signed [23:0] ovx_q, ovy_q;
  logic [15:0]        m2_q, dt_q;

  // Architectural state.
  logic [15:0]        own_mass_q;
  logic signed [23:0] vx_q, vy_q;
  logic signed [31:0] px_q, py_q;
  logic [15:0]        ball_cnt_q, border_cnt_q;
  logic               degen_q;

  // Working registers.
  logic [31:0]        norm2_q;
  logic signed [41:0] dot_q;
  logic signed [59:0] prod_q;
  logic [26:0]        t_q, dl_q;
  logic               comp_q;

  // Shared multiplier.
  logic signed [41:0] mul_a;
  logic signed [17:0] mul_b;
  logic signed [59:0] mul_p;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic               in_acc;
  logic [16:0]        msum;
  logic signed [15:0] c_sel;
  logic signed [23:0] v_sel;
  logic [41:0]        dot_mag;
  logic [16:0]        c_mag;
  logic               neg_dir;
  logic signed [28:0] v_new;
  logic signed [23:0] v_sat;
  logic [23:0]        vx_mag, vy_mag;
  logic [39:0]        step_sum;
  logic [23:0]        step;
  logic signed [31:0] p_sel;
  logic               v_neg;
  logic signed [33:0] p_new;
  logic signed [31:0] p_sat;
  logic signed [24:0] neg_x, neg_y;

  assign in_acc      = in_valid_i && !in_stall_o;
  assign in_stall_o  = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign msum        = {1'b0, own_mass_q} + {1'b0, m2_q};

  assign c_sel   = comp_q ? ay_q : ax_q;
  assign v_sel   = comp_q ? vy_q : vx_q;
  assign dot_mag = dot_q[41] ? 42'(-dot_q) : 42'(dot_q);
  assign c_mag   = c_sel[15] ? 17'(-{c_sel[15], c_sel}) : {1'b0, c_sel};
  assign neg_dir = dot_q[41] ^ c_sel[15];
  assign vx_mag  = vx_q[23] ? 24'(-{vx_q[23], vx_q}) : 24'(vx_q);
  assign vy_mag  = vy_q[23] ? 24'(-{vy_q[23], vy_q}) : 24'(vy_q);

  // Select multiplier operands for the current step.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      S_NRM_X: begin
        mul_a = 42'(ax_q);
        mul_b = 18'(ax_q);
      end
      S_NRM_Y: begin
        mul_a = 42'(ay_q);
        mul_b = 18'(ay_q);
      end
      S_DOT_X: begin
        mul_a = 42'(25'(ovx_q) - 25'(vx_q));
        mul_b = 18'(ax_q);
      end
      S_DOT_Y: begin
        mul_a = 42'(25'(ovy_q) - 25'(vy_q));
        mul_b = 18'(ay_q);
      end
      S_TMUL: begin
        mul_a = signed'(dot_mag);
        mul_b = signed'({1'b0, c_mag});
      end
      S_LMUL: begin
        mul_a = signed'({15'd0, t_q});
        mul_b = signed'({2'b00, m2_q});
      end
      S_IDLE, S_MV_Y: begin
        // S_IDLE feeds the x step of a move tick, S_MV_Y the y step.
        mul_a = signed'({18'd0, (state_q == S_IDLE) ? vx_mag : vy_mag});
        mul_b = signed'({2'b00, (state_q == S_IDLE) ? delta_time_i : dt_q});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // Velocity correction along one axis component, saturated.
  always_comb begin
    v_new = neg_dir ? (29'(v_sel) - signed'({2'b00, dl_q}))
                    : (29'(v_sel) + signed'({2'b00, dl_q}));
    if (v_new > 29'(VelMax))      v_sat = VelMax;
    else if (v_new < 29'(VelMin)) v_sat = VelMin;
    else                          v_sat = v_new[23:0];
  end

  // Position step, rounded on the magnitude, saturated.
  always_comb begin
    step_sum = prod_q[39:0] + 40'h8000;
    step     = step_sum[39:16];
    p_sel    = (state_q == S_MV_Y) ? px_q : py_q;
    v_neg    = (state_q == S_MV_Y) ? vx_q[23] : vy_q[23];
    p_new    = v_neg ? (34'(p_sel) - signed'({10'd0, step}))
                     : (34'(p_sel) + signed'({10'd0, step}));
    if (p_new > 34'(PosMax))      p_sat = PosMax;
    else if (p_new < 34'(PosMin)) p_sat = PosMin;
    else                          p_sat = p_new[31:0];
  end

  assign neg_x = -25'(vx_q);
  assign neg_y = -25'(vy_q);

  always_comb begin
    div_req.start = 1'b0;
    div_req.num   = '0;
    div_req.den   = '0;
    if (state_q == S_TDIV) begin
      div_req.start = 1'b1;
      div_req.num   = prod_q[57:0] + 58'(norm2_q >> 1);
      div_req.den   = norm2_q;
    end else if (state_q == S_LDIV) begin
      div_req.start = 1'b1;
      div_req.num   = {prod_q[56:0], 1'b0} + 58'(msum >> 1);
      div_req.den   = 32'(msum);
    end
  end

  decu_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // Sequencer.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          unique case (cmd_e'(command_i))
            CMD_BALL: state_d = S_NRM_X;
            CMD_MOVE: state_d = S_MV_Y;
            default:  state_d = S_OUT;
          endcase
        end
      end
      S_NRM_X: state_d = S_NRM_Y;
      S_NRM_Y: state_d = S_DOT_X;
      S_DOT_X: state_d = S_DOT_Y;
      S_DOT_Y: state_d = S_CHK;
      S_CHK:   state_d = (norm2_q == '0) ? S_OUT : S_TMUL;
      S_TMUL:  state_d = S_TDIV;
      S_TDIV:  state_d = S_TWAIT;
      S_TWAIT: state_d = div_rsp.done ? S_LMUL : S_TWAIT;
      S_LMUL:  state_d = (msum == '0) ? S_APPLY : S_LDIV;
      S_LDIV:  state_d = S_LWAIT;
      S_LWAIT: state_d = div_rsp.done ? S_APPLY : S_LWAIT;
      S_APPLY: state_d = comp_q ? S_OUT : S_TMUL;
      S_MV_Y:  state_d = S_MV_F;
      S_MV_F:  state_d = S_OUT;
      S_OUT:   state_d = out_stall_i ? S_OUT : S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      own_mass_q   <= 16'd256;
      vx_q         <= '0;
      vy_q         <= '0;
      px_q         <= '0;
      py_q         <= '0;
      ball_cnt_q   <= '0;
      border_cnt_q <= '0;
      degen_q      <= 1'b0;
      comp_q       <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) own_mass_q <= cfg_own_mass_i;
      unique case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            degen_q <= 1'b0;
            comp_q  <= 1'b0;
            unique case (cmd_e'(command_i))
              CMD_BORDER: begin
                // x normal wins; negating the most negative value saturates
                if (axis_x_i != '0) begin
                  vx_q <= (neg_x > 25'(VelMax)) ? VelMax : neg_x[23:0];
                end else if (axis_y_i != '0) begin
                  vy_q <= (neg_y > 25'(VelMax)) ? VelMax : neg_y[23:0];
                end
                border_cnt_q <= border_cnt_q + 16'd1;
              end
              CMD_BALL: ball_cnt_q <= ball_cnt_q + 16'd1;
              CMD_SET: begin
                vx_q <= other_vel_x_i;
                vy_q <= other_vel_y_i;
              end
              default: ;
            endcase
          end
        end
        S_CHK: degen_q <= (norm2_q == '0);
        S_APPLY: begin
          if (comp_q) vy_q <= v_sat;
          else        vx_q <= v_sat;
          comp_q <= 1'b1;
        end
        S_MV_Y: px_q <= p_sat;
        S_MV_F: py_q <= p_sat;
        default: ;
      endcase
    end
  end

  // Payload and working registers.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      cmd_q <= command_i;
      ax_q  <= axis_x_i;
      ay_q  <= axis_y_i;
      ovx_q <= other_vel_x_i;
      ovy_q <= other_vel_y_i;
      m2_q  <= other_mass_i;
      dt_q  <= delta_time_i;
    end
    unique case (state_q)
      S_IDLE, S_NRM_X, S_TMUL, S_LMUL, S_MV_Y: prod_q <= mul_p;
      S_NRM_Y: begin
        norm2_q <= prod_q[31:0];
        prod_q  <= mul_p;
      end
      S_DOT_X: begin
        norm2_q <= norm2_q + prod_q[31:0];
        prod_q  <= mul_p;
      end
      S_DOT_Y: begin
        dot_q  <= prod_q[41:0];
        prod_q <= mul_p;
      end
      S_CHK: dot_q <= dot_q + prod_q[41:0];
      S_TWAIT: if (div_rsp.done) t_q <= div_rsp.quo;
      default: ;
    endcase
    if (state_q == S_LMUL && msum == '0) dl_q <= '0;
    if (state_q == S_LWAIT && div_rsp.done) dl_q <= div_rsp.quo;
  end

  assign out_valid_o   = (state_q == S_OUT);
  assign vel_x_o       = vx_q;
  assign vel_y_o       = vy_q;
  assign pos_x_o       = px_q;
  assign pos_y_o       = py_q;
  assign ball_hits_o   = ball_cnt_q;
  assign border_hits_o = border_cnt_q;
  assign degenerate_o  = degen_q && (cmd_q == CMD_BALL);

endmodule

@@ hw/rtl/decu_div.sv @@
// ----------------------------------------------------------------------------
// decu_div
// Restoring bit-serial divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module decu_div
  import decu_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic [DivDenW-1:0] rem_q;
  logic [DivQuoW-1:0] quo_q;
  logic [DivDenW-1:0] den_q;
  logic [DivCntW-1:0] cnt_q;
  logic               busy_q;
  logic               done_q;
  logic [DivDenW:0]   trial;
  logic [DivDenW:0]   diff;
  logic               qbit;

  always_comb begin
    trial = {rem_q, quo_q[DivQuoW-1]};
    diff  = trial - {1'b0, den_q};
    qbit  = (trial >= {1'b0, den_q});
  end

  // Upper dividend bits are known to be below the divisor (quotient fits).
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == DivCntW'(1));
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= DivCntW'(DivQuoW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - DivCntW'(1);
        if (cnt_q == DivCntW'(1)) busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= {1'b0, req_i.num[DivNumW-1:DivQuoW]};
      quo_q <= req_i.num[DivQuoW-1:0];
      den_q <= req_i.den;
    end else if (busy_q) begin
      rem_q <= qbit ? diff[DivDenW-1:0] : trial[DivDenW-1:0];
      quo_q <= {quo_q[DivQuoW-2:0], qbit};
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = quo_q;

endmodule

@@ bench/disc_elastic_collision_update_top_test.sv @@
// ----------------------------------------------------------------------------
// disc_elastic_collision_update_top_test
// Self-checking bench for the disc elastic collision update block.
// ----------------------------------------------------------------------------
// A clocked driver sends command transactions from a queue that the stimulus
// process fills phase by phase. A clocked monitor predicts each accepted
// transaction from the bench's own copy of the disc state and compares every
// result transaction with the oldest prediction. own_mass is rewritten only
// between phases, once the block has drained.
// ----------------------------------------------------------------------------
module disc_elastic_collision_update_top_test;
  import decu_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam longint VelMax = 64'sd8388607;
  localparam longint VelMin = -64'sd8388608;
  localparam longint PosMax = 64'sd2147483647;
  localparam longint PosMin = -64'sd2147483648;
  localparam int unsigned CycleLimit = 1000000;

  typedef struct {
    cmd_e               cmd;
    logic signed [15:0] ax;
    logic signed [15:0] ay;
    logic signed [23:0] ovx;
    logic signed [23:0] ovy;
    logic        [15:0] m2;
    logic        [15:0] dt;
  } disc_cmd_t;

  typedef struct {
    logic signed [23:0] vx;
    logic signed [23:0] vy;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic        [15:0] balls;
    logic        [15:0] borders;
    logic               degen;
  } disc_state_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic        [15:0] cfg_own_mass_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic        [1:0]  command_i = '0;
  logic signed [15:0] axis_x_i = '0;
  logic signed [15:0] axis_y_i = '0;
  logic signed [23:0] other_vel_x_i = '0;
  logic signed [23:0] other_vel_y_i = '0;
  logic        [15:0] other_mass_i = '0;
  logic        [15:0] delta_time_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic signed [23:0] vel_x_o;
  logic signed [23:0] vel_y_o;
  logic signed [31:0] pos_x_o;
  logic signed [31:0] pos_y_o;
  logic        [15:0] ball_hits_o;
  logic        [15:0] border_hits_o;
  logic               degenerate_o;

  disc_elastic_collision_update_top u_top (.*);

  always #2 clk_i = ~clk_i;

  // Bench copy of the disc and of its mass register.
  longint          disc_vx, disc_vy, disc_px, disc_py;
  int unsigned     disc_balls, disc_borders;
  longint unsigned disc_mass = 256;

  disc_cmd_t   cmd_queue[$];
  disc_state_t expected_states[$];
  disc_cmd_t   cmd_on_bus;
  bit          cmd_taken = 1'b0;
  int          send_gap = 0;
  int          stall_left = 0;
  bit          send_calm = 1'b0;
  bit          recv_calm = 1'b0;
  int unsigned cycle_count = 0;
  int unsigned fail_count = 0;

  function automatic longint clamp(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint unsigned magnitude(longint v);
    return v < 0 ? longint'(-v) : v;
  endfunction

  // Normal-axis velocity change for one component; products wrap at 64 bits.
  function automatic longint collide_component(longint v1c, longint d, longint c,
                                               longint unsigned norm2,
                                               longint unsigned m2,
                                               longint unsigned msum);
    longint unsigned t, dl;
    t  = (magnitude(d) * magnitude(c) + norm2 / 2) / norm2;
    dl = (msum != 0) ? (64'd2 * m2 * t + msum / 2) / msum : 64'd0;
    if ((d < 0) != (c < 0)) return clamp(v1c - longint'(dl), VelMin, VelMax);
    return clamp(v1c + longint'(dl), VelMin, VelMax);
  endfunction

  function automatic longint advance_position(longint pos, longint v,
                                              longint unsigned dt);
    longint unsigned step;
    step = (magnitude(v) * dt + 64'd32768) >> 16;
    if (v < 0) return clamp(pos - longint'(step), PosMin, PosMax);
    return clamp(pos + longint'(step), PosMin, PosMax);
  endfunction

  function automatic disc_state_t update_disc(disc_cmd_t c);
    disc_state_t     s;
    longint          ax, ay, d, nx;
    longint unsigned norm2;
    ax = c.ax;
    ay = c.ay;
    s.degen = 1'b0;
    case (c.cmd)
      CMD_BORDER: begin
        if (ax != 0) disc_vx = clamp(-disc_vx, VelMin, VelMax);
        else if (ay != 0) disc_vy = clamp(-disc_vy, VelMin, VelMax);
        disc_borders = (disc_borders + 1) & 16'hFFFF;
      end
      CMD_BALL: begin
        norm2 = ax * ax + ay * ay;
        if (norm2 == 0) begin
          s.degen = 1'b1;
        end else begin
          d  = (longint'(c.ovx) - disc_vx) * ax + (longint'(c.ovy) - disc_vy) * ay;
          nx = collide_component(disc_vx, d, ax, norm2, c.m2, disc_mass + c.m2);
          disc_vy = collide_component(disc_vy, d, ay, norm2, c.m2, disc_mass + c.m2);
          disc_vx = nx;
        end
        disc_balls = (disc_balls + 1) & 16'hFFFF;
      end
      CMD_MOVE: begin
        disc_px = advance_position(disc_px, disc_vx, c.dt);
        disc_py = advance_position(disc_py, disc_vy, c.dt);
      end
      default: begin
        disc_vx = c.ovx;
        disc_vy = c.ovy;
      end
    endcase
    s.vx = disc_vx[23:0];
    s.vy = disc_vy[23:0];
    s.px = disc_px[31:0];
    s.py = disc_py[31:0];
    s.balls = disc_balls[15:0];
    s.borders = disc_borders[15:0];
    return s;
  endfunction

  // Mostly short gaps, a few long ones, and calm stretches with none.
  function automatic int pick_gap(bit calm);
    if (calm || $urandom_range(0, 9) < 6) return 0;
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Driver: hold the payload while stalled, advance after each transaction.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || cmd_taken) begin
        if (cmd_taken) begin
          cmd_taken = 1'b0;
          if ($urandom_range(0, 63) == 0) send_calm = !send_calm;
          send_gap = pick_gap(send_calm);
        end
        if (send_gap > 0) begin
          send_gap--;
          in_valid_i <= 1'b0;
        end else if (cmd_queue.size() > 0) begin
          cmd_on_bus = cmd_queue.pop_front();
          in_valid_i    <= 1'b1;
          command_i     <= cmd_on_bus.cmd;
          axis_x_i      <= cmd_on_bus.ax;
          axis_y_i      <= cmd_on_bus.ay;
          other_vel_x_i <= cmd_on_bus.ovx;
          other_vel_y_i <= cmd_on_bus.ovy;
          other_mass_i  <= cmd_on_bus.m2;
          delta_time_i  <= cmd_on_bus.dt;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      // Receiver back-pressure.
      if (stall_left > 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else begin
        if ($urandom_range(0, 127) == 0) recv_calm = !recv_calm;
        stall_left = pick_gap(recv_calm);
        out_stall_i <= (stall_left > 0);
        if (stall_left > 0) stall_left--;
      end
    end
  end

  // Monitor: predict on accept, check on result, enforce the cycle limit.
  always @(posedge clk_i) begin
    disc_state_t want;
    if (rst_ni) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
        $display("TEST FAILED");
        $finish;
      end else begin
        if (in_valid_i && !in_stall_o) begin
          expected_states.push_back(update_disc(cmd_on_bus));
          cmd_taken = 1'b1;
        end
        if (out_valid_o && !out_stall_i) begin
          if (expected_states.size() == 0) begin
            $error("result transaction with no prediction waiting");
            fail_count++;
          end else begin
            want = expected_states.pop_front();
            if (vel_x_o !== want.vx) begin
              $error("vel_x expected %0d actual %0d", want.vx, vel_x_o);
              fail_count++;
            end
            if (vel_y_o !== want.vy) begin
              $error("vel_y expected %0d actual %0d", want.vy, vel_y_o);
              fail_count++;
            end
            if (pos_x_o !== want.px) begin
              $error("pos_x expected %0d actual %0d", want.px, pos_x_o);
              fail_count++;
            end
            if (pos_y_o !== want.py) begin
              $error("pos_y expected %0d actual %0d", want.py, pos_y_o);
              fail_count++;
            end
            if (ball_hits_o !== want.balls) begin
              $error("ball_hits expected %0d actual %0d", want.balls, ball_hits_o);
              fail_count++;
            end
            if (border_hits_o !== want.borders) begin
              $error("border_hits expected %0d actual %0d", want.borders,
                     border_hits_o);
              fail_count++;
            end
            if (degenerate_o !== want.degen) begin
              $error("degenerate expected %0d actual %0d", want.degen, degenerate_o);
              fail_count++;
            end
          end
        end
      end
    end
  end

  function automatic disc_cmd_t make_cmd(cmd_e cmd, int ax, int ay, int ovx,
                                         int ovy, int m2, int dt);
    disc_cmd_t c;
    c.cmd = cmd;
    c.ax = 16'(ax);
    c.ay = 16'(ay);
    c.ovx = 24'(ovx);
    c.ovy = 24'(ovy);
    c.m2 = 16'(m2);
    c.dt = 16'(dt);
    return c;
  endfunction

  function automatic logic [15:0] rand_axis();
    case ($urandom_range(0, 7))
      0:       return 16'sd0;
      1:       return 16'sh8000;
      2:       return 16'sh7FFF;
      3:       return 16'(int'($urandom_range(0, 32)) - 16);
      default: return 16'($urandom());
    endcase
  endfunction

  function automatic logic [23:0] rand_vel();
    case ($urandom_range(0, 7))
      0:       return 24'h800000;
      1:       return 24'h7FFFFF;
      2:       return 24'(int'($urandom_range(0, 8192)) - 4096);
      default: return 24'($urandom());
    endcase
  endfunction

  function automatic logic [15:0] rand_mass();
    case ($urandom_range(0, 9))
      0:       return 16'd1;
      1:       return 16'hFFFF;
      default: return 16'($urandom_range(1, 65535));
    endcase
  endfunction

  // Random command; with travel set, mostly long move ticks to reach the
  // position limits.
  function automatic disc_cmd_t rand_cmd(bit travel);
    disc_cmd_t c;
    c = make_cmd(cmd_e'($urandom_range(0, 3)), 0, 0, 0, 0, 1, 0);
    c.ax = rand_axis();
    c.ay = ($urandom_range(0, 3) == 0) ? 16'sd0 : rand_axis();
    if ($urandom_range(0, 7) == 0) c.ax = 16'sd0;
    c.ovx = rand_vel();
    c.ovy = rand_vel();
    c.m2 = rand_mass();
    c.dt = 16'($urandom());
    if (travel) begin
      if ($urandom_range(0, 19) == 0) begin
        c.cmd = CMD_SET;
        c.ovx = $urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000;
        c.ovy = $urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000;
      end else begin
        c.cmd = CMD_MOVE;
        if ($urandom_range(0, 3) != 0) c.dt = 16'hFFFF;
      end
    end
    return c;
  endfunction

  task automatic wait_drained();
    @(posedge clk_i);
    while (cmd_queue.size() > 0 || in_valid_i || expected_states.size() > 0)
      @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_mass(logic [15:0] mass);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_own_mass_i <= mass;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    disc_mass = mass;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic run_random(int count, bit travel);
    repeat (count) cmd_queue.push_back(rand_cmd(travel));
    wait_drained();
  endtask

  initial begin
    disc_vx = 0;
    disc_vy = 0;
    disc_px = 0;
    disc_py = 0;
    disc_balls = 0;
    disc_borders = 0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: extremes and the corner cases, reset mass.
    cmd_queue.push_back(make_cmd(CMD_SET, 0, 0, -8388608, 8388607, 1, 0));
    cmd_queue.push_back(make_cmd(CMD_BORDER, 1, 0, 0, 0, 1, 0));       // saturate
    cmd_queue.push_back(make_cmd(CMD_BORDER, 0, -32768, 0, 0, 1, 0));
    cmd_queue.push_back(make_cmd(CMD_BORDER, -5, 7, 0, 0, 1, 0));      // x wins
    cmd_queue.push_back(make_cmd(CMD_BORDER, 0, 0, 0, 0, 1, 0));       // no normal
    cmd_queue.push_back(make_cmd(CMD_BALL, 0, 0, 1000, -1000, 256, 0)); // no axis
    cmd_queue.push_back(make_cmd(CMD_MOVE, 0, 0, 0, 0, 1, 65535));
    cmd_queue.push_back(make_cmd(CMD_MOVE, 0, 0, 0, 0, 1, 0));
    cmd_queue.push_back(make_cmd(CMD_SET, 0, 0, 2560, -512, 1, 0));
    cmd_queue.push_back(make_cmd(CMD_BALL, 16384, 0, -2560, 0, 256, 0));
    cmd_queue.push_back(make_cmd(CMD_BALL, -32768, -32768, 8388607, -8388608,
                                 65535, 0));
    cmd_queue.push_back(make_cmd(CMD_BALL, 32767, 32767, -8388608, 8388607, 1, 0));
    cmd_queue.push_back(make_cmd(CMD_BALL, 1, 1, 8388607, 8388607, 65535, 0));
    cmd_queue.push_back(make_cmd(CMD_BALL, 11585, -11585, 300, 200, 0, 0));
    cmd_queue.push_back(make_cmd(CMD_MOVE, 0, 0, 0, 0, 1, 32768));
    cmd_queue.push_back(make_cmd(CMD_SET, 0, 0, 1, -1, 1, 0));
    cmd_queue.push_back(make_cmd(CMD_MOVE, 0, 0, 0, 0, 1, 32768));     // tie
    cmd_queue.push_back(make_cmd(CMD_MOVE, 0, 0, 0, 0, 1, 32767));
    wait_drained();

    // Own mass zero: with a zero other mass the sum is zero and the velocity is kept, then a nonzero other mass.
    write_mass(16'd0);
    cmd_queue.push_back(make_cmd(CMD_SET, 0, 0, 4096, -4096, 1, 0));
    cmd_queue.push_back(make_cmd(CMD_BALL, 16384, 16384, -4096, 4096, 0, 0));
    cmd_queue.push_back(make_cmd(CMD_BALL, 16384, 0, -4096, 4096, 300, 0));
    wait_drained();

    write_mass(16'd1);
    run_random(180, 1'b0);
    write_mass(16'hFFFF);
    run_random(120, 1'b0);
    write_mass(16'(int'($urandom_range(1, 65535))));
    run_random(280, 1'b1);
    write_mass(16'd256);
    run_random(70, 1'b0);

    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/decu_pkg.sv
hw/rtl/decu_div.sv
hw/rtl/disc_elastic_collision_update_top.sv
bench/disc_elastic_collision_update_top_test.sv
